>>> design/imusgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU scale and gyro bias removal - shared definitions
// Widths, register indexes, payload structs and state encodings.
// ----------------------------------------------------------------------------
package imusgb_pkg;

    localparam int AXES           = 3;
    localparam int AXIS_COUNT_DEF = 3;
    localparam int RAW_W          = 16;
    localparam int SCALE_W        = 32;
    localparam int CNT_W          = 16;
    localparam int OUT_W          = 48;
    localparam int SUM_W          = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CNT_W-1:0] CALIB_SAMPLES_RST = 16'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES = 2'd2;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_gyro_x;
        logic signed [RAW_W-1:0] raw_gyro_y;
        logic signed [RAW_W-1:0] raw_gyro_z;
        logic signed [RAW_W-1:0] raw_accel_x;
        logic signed [RAW_W-1:0] raw_accel_y;
        logic signed [RAW_W-1:0] raw_accel_z;
        logic                    start_calibration;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] accel_x;
        logic signed [OUT_W-1:0] accel_y;
        logic signed [OUT_W-1:0] accel_z;
        logic signed [OUT_W-1:0] gyro_x;
        logic signed [OUT_W-1:0] gyro_y;
        logic signed [OUT_W-1:0] gyro_z;
        logic                    calibrated;
        logic                    calibrating;
    } out_t;

    // Scaled sample waiting between front and back
    typedef struct packed {
        logic [AXES-1:0][OUT_W-1:0] gyro_prod;
        logic [AXES-1:0][OUT_W-1:0] accel_prod;
        logic                       start;
    } q_entry_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DISCARD = 2'd1,
        PH_ACCUM   = 2'd2
    } phase_t;

    typedef enum logic {
        BK_RUN = 1'b0,
        BK_DIV = 1'b1
    } bk_state_t;

endpackage

>>> design/imusgb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU front end
// Accepts raw samples, scales the first AXIS_COUNT axes (others read zero) and tags calibration starts.
// ----------------------------------------------------------------------------
module imusgb_front
    import imusgb_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  in_t                sample,
    input  logic [SCALE_W-1:0] accel_scale,
    input  logic [SCALE_W-1:0] gyro_scale,
    output logic               push_valid,
    input  logic               push_ready,
    output q_entry_t           push_data
);

    logic     stg_valid_reg;
    logic     stg_valid_next;
    q_entry_t stg_data_reg;
    q_entry_t stg_data_next;

    logic [RAW_W-1:0] raw_gyro  [AXES];
    logic [RAW_W-1:0] raw_accel [AXES];
    logic [OUT_W-1:0] gyro_prod [AXES];
    logic [OUT_W-1:0] accel_prod[AXES];

    assign raw_gyro[0]  = sample.raw_gyro_x;
    assign raw_gyro[1]  = sample.raw_gyro_y;
    assign raw_gyro[2]  = sample.raw_gyro_z;
    assign raw_accel[0] = sample.raw_accel_x;
    assign raw_accel[1] = sample.raw_accel_y;
    assign raw_accel[2] = sample.raw_accel_z;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        if (a < AXIS_COUNT) begin : g_mul
            logic signed [RAW_W+SCALE_W:0] gp;
            logic signed [RAW_W+SCALE_W:0] ap;
            assign gp = $signed(raw_gyro[a]) * $signed({1'b0, gyro_scale});
            assign ap = $signed(raw_accel[a]) * $signed({1'b0, accel_scale});
            assign gyro_prod[a]  = gp[OUT_W-1:0];
            assign accel_prod[a] = ap[OUT_W-1:0];
        end
        else begin : g_off
            assign gyro_prod[a]  = '0;
            assign accel_prod[a] = '0;
        end
    end

    assign sample_ready = !stg_valid_reg || push_ready;
    assign push_valid   = stg_valid_reg;
    assign push_data    = stg_data_reg;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_data_next  = stg_data_reg;
        if (push_valid && push_ready)
        begin
            stg_valid_next = 1'b0;
        end
        if (sample_valid && sample_ready)
        begin
            stg_valid_next = 1'b1;
            for (int a = 0; a < AXES; a++)
            begin
                stg_data_next.gyro_prod[a]  = gyro_prod[a];
                stg_data_next.accel_prod[a] = accel_prod[a];
            end
            stg_data_next.start = sample.start_calibration;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_data_reg <= stg_data_next;
    end

endmodule

>>> design/imusgb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU front-to-back queue
// Two-entry FIFO of scaled samples between the front and the back.
// ----------------------------------------------------------------------------
module imusgb_queue
    import imusgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_data,
    output logic     pop_valid,
    input  logic     pop,
    output q_entry_t pop_data
);

    q_entry_t   entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/imusgb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU bias divider
// Restoring divider, one quotient bit per cycle, one lane per axis.
// ----------------------------------------------------------------------------
module imusgb_div
    import imusgb_pkg::*;
#(
    parameter int LANES = AXIS_COUNT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  div_req_t                     req,
    input  logic [LANES-1:0][SUM_W-1:0]  dividend,
    output div_rsp_t                     rsp,
    output logic [LANES-1:0][OUT_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  divisor_reg;

    function automatic logic [OUT_W-1:0] sat_quot(input logic [SUM_W-1:0] q);
        logic [SUM_W-OUT_W:0] top;
        top = q[SUM_W-1:OUT_W-1];
        if ((&top) || !(|top))
        begin
            return q[OUT_W-1:0];
        end
        return q[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [SUM_W-1:0] mag_reg;
        logic [CNT_W-1:0] rem_reg;
        logic             neg_reg;
        logic [CNT_W:0]   trial;
        logic             fits;

        assign trial = {rem_reg, mag_reg[SUM_W-1]};
        assign fits  = (trial >= {1'b0, divisor_reg});
        assign quotient[l] = sat_quot(neg_reg ? (~mag_reg + 1'b1) : mag_reg);

        always_ff @(posedge clk)
        begin
            if (req.start)
            begin
                neg_reg <= dividend[l][SUM_W-1];
                mag_reg <= dividend[l][SUM_W-1] ? (~dividend[l] + 1'b1) : dividend[l];
                rem_reg <= '0;
            end
            else if (busy_reg)
            begin
                // shift in the next dividend bit, keep the quotient bit
                rem_reg <= fits ? CNT_W'(trial - {1'b0, divisor_reg}) : trial[CNT_W-1:0];
                mag_reg <= {mag_reg[SUM_W-2:0], fits};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEPS;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
        end
    end

endmodule

>>> design/imusgb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU back end
// Removes gyro bias, runs the calibration phases and holds the result.
// ----------------------------------------------------------------------------
module imusgb_back
    import imusgb_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [CNT_W-1:0]                 calib_samples,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  q_entry_t                         q_data,
    output logic                             result_valid,
    input  logic                             result_ready,
    output out_t                             result,
    output div_req_t                         div_req,
    output logic [AXIS_COUNT-1:0][SUM_W-1:0] div_dividend,
    input  div_rsp_t                         div_rsp,
    input  logic [AXIS_COUNT-1:0][OUT_W-1:0] div_quot
);

    bk_state_t        state_reg;
    bk_state_t        state_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             calib_reg;
    logic             calib_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    out_t             result_reg;
    out_t             result_next;
    logic             consumed;
    logic             accum;
    logic             finish;

    logic [SUM_W-1:0] sum_reg  [AXIS_COUNT];
    logic [SUM_W-1:0] sum_next [AXIS_COUNT];
    logic [OUT_W-1:0] bias_reg [AXIS_COUNT];
    logic [OUT_W-1:0] gyro_out [AXES];

    function automatic logic [OUT_W-1:0] sat_diff(input logic [OUT_W:0] d);
        if (d[OUT_W] == d[OUT_W-1])
        begin
            return d[OUT_W-1:0];
        end
        return d[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        if (g < AXIS_COUNT) begin : g_on
            logic [OUT_W-1:0] gp;
            logic [OUT_W-1:0] bias_eff;
            assign gp       = q_data.gyro_prod[g];
            assign bias_eff = q_data.start ? '0 : bias_reg[g];
            assign gyro_out[g] = sat_diff({gp[OUT_W-1], gp} - {bias_eff[OUT_W-1], bias_eff});
            assign sum_next[g] = (q_data.start ? '0 : sum_reg[g])
                               + (accum ? {{(SUM_W-OUT_W){gp[OUT_W-1]}}, gp} : '0);
            assign div_dividend[g] = sum_next[g];
        end
        else begin : g_off
            assign gyro_out[g] = '0;
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] half;
        logic [CNT_W-1:0] cnt_eff;
        logic [CNT_W-1:0] cnt_inc;
        phase_t           ph_eff;

        n       = (calib_samples == '0) ? CNT_W'(1) : calib_samples;
        half    = n >> 1;
        ph_eff  = q_data.start ? PH_DISCARD : phase_reg;
        cnt_eff = q_data.start ? '0 : cnt_reg;
        cnt_inc = '0;

        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        calib_next     = calib_reg;
        res_valid_next = res_valid_reg;
        result_next    = result_reg;
        consumed       = 1'b0;
        accum          = 1'b0;
        finish         = 1'b0;
        q_pop          = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = n;

        if (result_valid && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_RUN:
            begin
                q_pop = q_valid && (!res_valid_reg || result_ready);
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase

        // phase walk for the sample at the head of the queue
        phase_next = ph_eff;
        cnt_next = cnt_eff;
        if (ph_eff == PH_DISCARD)
        begin
            if (cnt_eff < half)
            begin
                cnt_next = cnt_eff + 1'b1;
                consumed = 1'b1;
            end
            else
            begin
                phase_next = PH_ACCUM;
                cnt_next   = '0;
            end
        end
        if (!consumed && phase_next == PH_ACCUM)
        begin
            consumed = 1'b1;
            accum    = 1'b1;
            cnt_inc  = cnt_next + 1'b1;
            if (cnt_inc >= n)
            begin
                finish     = 1'b1;
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end

        if (q_pop)
        begin
            if (finish)
            begin
                calib_next    = 1'b1;
                div_req.start = 1'b1;
                state_next    = BK_DIV;
            end
            res_valid_next          = 1'b1;
            result_next.accel_x     = q_data.accel_prod[0];
            result_next.accel_y     = q_data.accel_prod[1];
            result_next.accel_z     = q_data.accel_prod[2];
            result_next.gyro_x      = gyro_out[0];
            result_next.gyro_y      = gyro_out[1];
            result_next.gyro_z      = gyro_out[2];
            result_next.calibrated  = calib_next;
            result_next.calibrating = consumed;
        end
        else
        begin
            phase_next = phase_reg;
            cnt_next   = cnt_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            calib_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                sum_reg[a]  <= '0;
                bias_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            calib_reg     <= calib_next;
            res_valid_reg <= res_valid_next;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                if (q_pop)
                begin
                    sum_reg[a] <= sum_next[a];
                    if (q_data.start)
                    begin
                        bias_reg[a] <= '0;
                    end
                end
                else if (state_reg == BK_DIV && div_rsp.done)
                begin
                    bias_reg[a] <= div_quot[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> !q_pop)
        else $error("sample taken while bias divide in progress");

    a_finish_enters_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> state_reg == BK_DIV && div_rsp.busy)
        else $error("calibration end did not start the divider");

    a_done_only_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == BK_DIV)
        else $error("divider finished outside the divide state");

    a_start_clears_bias: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_data.start |=> bias_reg[0] == '0)
        else $error("start flag left a stale bias");
`endif

endmodule

>>> design/imu_scale_and_gyro_bias_removal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU scale and gyro bias removal - top level
// Scales raw gyro and accel samples to Q.24 and removes calibrated gyro bias.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  sample    sample_valid / sample_ready  sample  (in_t)
//  result    result_valid / result_ready  result  (out_t)
//  config    cfg_write_en                 cfg_index, cfg_wdata
//
//  A result is valid once its sample has passed the scale stage, the queue
//  and the output register; one sample per cycle sustained while no divide
//  runs and the result side does not stall. A calibration-ending sample
//  starts a 64-step bit-serial divide; the back end takes no sample until it
//  is done, while the front keeps filling its stage and the two-entry queue.
//  Reset is asynchronous, active low; either side may stall without loss.
// ----------------------------------------------------------------------------
module imu_scale_and_gyro_bias_removal_top
    import imusgb_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  in_t                   sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_t                  result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SCALE_W-1:0] accel_scale_reg;
    logic [SCALE_W-1:0] gyro_scale_reg;
    logic [CNT_W-1:0]   calib_samples_reg;

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_data;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_data;

    div_req_t                         div_req;
    div_rsp_t                         div_rsp;
    logic [AXIS_COUNT-1:0][SUM_W-1:0] div_dividend;
    logic [AXIS_COUNT-1:0][OUT_W-1:0] div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg   <= '0;
            gyro_scale_reg    <= '0;
            calib_samples_reg <= CALIB_SAMPLES_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ACCEL_SCALE:   accel_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                CFG_GYRO_SCALE:    gyro_scale_reg    <= cfg_wdata[SCALE_W-1:0];
                CFG_CALIB_SAMPLES: calib_samples_reg <= cfg_wdata[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    imusgb_front #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .accel_scale  (accel_scale_reg),
        .gyro_scale   (gyro_scale_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    imusgb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    imusgb_div #(
        .LANES (AXIS_COUNT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .rsp      (div_rsp),
        .quotient (div_quot)
    );

    imusgb_back #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .calib_samples (calib_samples_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .div_req       (div_req),
        .div_dividend  (div_dividend),
        .div_rsp       (div_rsp),
        .div_quot      (div_quot)
    );

endmodule
